@@ design/ppd_pkg.sv @@
// shared types and constants of the packet port dispatcher
`default_nettype none

package ppd_pkg;

    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int PORT_W     = 16;
    localparam int TYPE_W     = 8;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 24;

    localparam logic [7:0]        UNASSIGNED_ADDR = 8'hFF;
    localparam logic [PORT_W-1:0] DYN_PORT_BASE   = 16'hF000;

    typedef enum logic [2:0] {
        ACT_CLASSIFY = 3'd0,
        ACT_ASSIGN   = 3'd1,
        ACT_WR_REQ   = 3'd2,
        ACT_WR_SVC   = 3'd3,
        ACT_WR_ICMP  = 3'd4
    } action_t;

    localparam logic [1:0] KIND_UDP  = 2'd0;
    localparam logic [1:0] KIND_ICMP = 2'd1;

    localparam logic [1:0] DST_FREE = 2'd0;
    localparam logic [1:0] DST_REQ  = 2'd1;
    localparam logic [1:0] DST_SVC  = 2'd2;
    localparam logic [1:0] DST_ICMP = 2'd3;

    typedef enum logic [1:0] {
        TBL_REQ  = 2'd0,
        TBL_SVC  = 2'd1,
        TBL_ICMP = 2'd2
    } tbl_t;

    typedef struct packed {
        logic              active;
        logic [PORT_W-1:0] next_port;
        logic [PORT_W-1:0] range_end;
        logic [PORT_W-1:0] range_begin;
    } req_entry_t;

    typedef struct packed {
        logic             en;
        tbl_t             tbl;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        tbl_t              tbl;
        logic [IDX_W-1:0]  idx;
        req_entry_t        req;
        logic [PORT_W-1:0] svc_port;
        logic [TYPE_W-1:0] msg_type;
        logic              vld;
    } wr_req_t;

    typedef struct packed {
        req_entry_t        req;
        logic              req_vld;
        logic [PORT_W-1:0] svc_port;
        logic              svc_vld;
        logic [TYPE_W-1:0] msg_type;
        logic              icmp_vld;
    } rd_rsp_t;

    typedef struct packed {
        logic              ok;
        logic [PORT_W-1:0] sport;
        logic [IDX_W-1:0]  idx;
        logic [1:0]        dst;
    } result_t;

endpackage

`default_nettype wire

@@ design/ppd_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module ppd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/ppd_tables.sv @@
// requester, service and icmp handler tables with their valid marks
`default_nettype none

module ppd_tables #(
    parameter int REQUESTERS    = 8,
    parameter int SERVICES      = 16,
    parameter int ICMP_HANDLERS = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ppd_pkg::rd_req_t rd_req,
    input  wire ppd_pkg::wr_req_t wr_req,
    output ppd_pkg::rd_rsp_t      rd_rsp
);

    localparam int RQ_AW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
    localparam int SV_AW = (SERVICES > 1) ? $clog2(SERVICES) : 1;
    localparam int IC_AW = (ICMP_HANDLERS > 1) ? $clog2(ICMP_HANDLERS) : 1;
    localparam int RQ_W  = $bits(ppd_pkg::req_entry_t);

    logic                       rq_re, rq_we, sv_re, sv_we, ic_re, ic_we;
    logic [RQ_AW-1:0]           rq_raddr, rq_waddr;
    logic [SV_AW-1:0]           sv_raddr, sv_waddr;
    logic [IC_AW-1:0]           ic_raddr, ic_waddr;
    logic [RQ_W-1:0]            rq_rdata;
    logic [ppd_pkg::PORT_W-1:0] sv_rdata;
    logic [ppd_pkg::TYPE_W-1:0] ic_rdata;

    logic [REQUESTERS-1:0]    req_vld_reg;
    logic [SERVICES-1:0]      svc_vld_reg;
    logic [ICMP_HANDLERS-1:0] icmp_vld_reg;
    logic                     rq_vld_q, sv_vld_q, ic_vld_q;

    assign rq_re = rd_req.en && (rd_req.tbl == ppd_pkg::TBL_REQ);
    assign sv_re = rd_req.en && (rd_req.tbl == ppd_pkg::TBL_SVC);
    assign ic_re = rd_req.en && (rd_req.tbl == ppd_pkg::TBL_ICMP);
    assign rq_we = wr_req.en && (wr_req.tbl == ppd_pkg::TBL_REQ);
    assign sv_we = wr_req.en && (wr_req.tbl == ppd_pkg::TBL_SVC);
    assign ic_we = wr_req.en && (wr_req.tbl == ppd_pkg::TBL_ICMP);

    assign rq_raddr = rd_req.idx[RQ_AW-1:0];
    assign sv_raddr = rd_req.idx[SV_AW-1:0];
    assign ic_raddr = rd_req.idx[IC_AW-1:0];
    assign rq_waddr = wr_req.idx[RQ_AW-1:0];
    assign sv_waddr = wr_req.idx[SV_AW-1:0];
    assign ic_waddr = wr_req.idx[IC_AW-1:0];

    ppd_ram #(.WIDTH(RQ_W), .DEPTH(REQUESTERS)) u_req_ram (
        .aclk  (aclk),
        .we    (rq_we),
        .waddr (rq_waddr),
        .wdata (wr_req.req),
        .re    (rq_re),
        .raddr (rq_raddr),
        .rdata (rq_rdata)
    );

    ppd_ram #(.WIDTH(ppd_pkg::PORT_W), .DEPTH(SERVICES)) u_svc_ram (
        .aclk  (aclk),
        .we    (sv_we),
        .waddr (sv_waddr),
        .wdata (wr_req.svc_port),
        .re    (sv_re),
        .raddr (sv_raddr),
        .rdata (sv_rdata)
    );

    ppd_ram #(.WIDTH(ppd_pkg::TYPE_W), .DEPTH(ICMP_HANDLERS)) u_icmp_ram (
        .aclk  (aclk),
        .we    (ic_we),
        .waddr (ic_waddr),
        .wdata (wr_req.msg_type),
        .re    (ic_re),
        .raddr (ic_raddr),
        .rdata (ic_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg  <= '0;
            svc_vld_reg  <= '0;
            icmp_vld_reg <= '0;
        end else begin
            if (rq_we) begin
                req_vld_reg[rq_waddr] <= wr_req.vld;
            end
            if (sv_we) begin
                svc_vld_reg[sv_waddr] <= wr_req.vld;
            end
            if (ic_we) begin
                icmp_vld_reg[ic_waddr] <= wr_req.vld;
            end
        end
    end

    // valid marks read alongside the ram data
    always_ff @(posedge aclk) begin
        if (rq_re) begin
            rq_vld_q <= req_vld_reg[rq_raddr];
        end
        if (sv_re) begin
            sv_vld_q <= svc_vld_reg[sv_raddr];
        end
        if (ic_re) begin
            ic_vld_q <= icmp_vld_reg[ic_raddr];
        end
    end

    always_comb begin
        rd_rsp.req      = ppd_pkg::req_entry_t'(rq_rdata);
        rd_rsp.req_vld  = rq_vld_q;
        rd_rsp.svc_port = sv_rdata;
        rd_rsp.svc_vld  = sv_vld_q;
        rd_rsp.msg_type = ic_rdata;
        rd_rsp.icmp_vld = ic_vld_q;
    end

endmodule

`default_nettype wire

@@ design/packet_port_dispatcher.sv @@
// packet port dispatcher top level: sequencer, item and result registers
// one item at a time: writes go decode then done, assign goes decode, assign, done
// classify scans one table entry per cycle through a single table read port:
// it ends at the first hit or after the last entry, and is skipped when not needed
// the next item can be taken as soon as a result enters the output register
// reset clears all valid marks at once and sets node_address to 255; no clearing pass
`default_nettype none

module packet_port_dispatcher #(
    parameter int REQUESTERS    = 8,
    parameter int SERVICES      = 16,
    parameter int ICMP_HANDLERS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // dst_port, message_type, entry_index, range_begin, range_end, entry_active,
    // entry_valid, zero fill
    input  wire logic [ppd_pkg::IN_DATA_W-1:0] s_tdata,
    // action, packet_kind
    input  wire logic [ppd_pkg::IN_USER_W-1:0] s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // destination, dest_index, source_port, ok, zero fill
    output logic      [ppd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int CW = ppd_pkg::CNT_W;
    localparam logic [CW-1:0] RQ_CNT = CW'(REQUESTERS);
    localparam logic [CW-1:0] SV_CNT = CW'(SERVICES);
    localparam logic [CW-1:0] IC_CNT = CW'(ICMP_HANDLERS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_ASSIGN = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    ppd_pkg::action_t               act_reg;
    logic [1:0]                     kind_reg;
    logic [ppd_pkg::PORT_W-1:0]     port_reg, rb_reg, re_reg;
    logic [ppd_pkg::TYPE_W-1:0]     mtype_reg;
    logic [ppd_pkg::IDX_W-1:0]      ei_reg;
    logic                           eact_reg, evld_reg;
    logic [7:0]                     node_reg;

    ppd_pkg::result_t               res_reg, res_next;
    logic [CW-1:0]                  cnt_reg, cnt_next, limit_reg, limit_next;
    logic                           pend_reg, pend_next;
    logic [ppd_pkg::IDX_W-1:0]      pidx_reg, pidx_next;
    ppd_pkg::tbl_t                  tbl_reg, tbl_next;
    logic                           m_tvalid_reg;
    logic [ppd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                           out_load;

    ppd_pkg::rd_req_t               rd_req;
    ppd_pkg::wr_req_t               wr_req;
    ppd_pkg::rd_rsp_t               rd_rsp;

    logic                           in_xfer;
    logic                           req_hit, svc_hit, icmp_hit, tbl_hit;
    logic [ppd_pkg::PORT_W-1:0]     port_inc;

    ppd_tables #(
        .REQUESTERS    (REQUESTERS),
        .SERVICES      (SERVICES),
        .ICMP_HANDLERS (ICMP_HANDLERS)
    ) u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_rsp  (rd_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign req_hit  = rd_rsp.req_vld && (port_reg >= rd_rsp.req.range_begin)
                      && (port_reg < rd_rsp.req.range_end);
    assign svc_hit  = rd_rsp.svc_vld && (rd_rsp.svc_port == port_reg);
    assign icmp_hit = rd_rsp.icmp_vld && (rd_rsp.msg_type == mtype_reg);
    assign port_inc = rd_rsp.req.next_port + 16'd1;

    always_comb begin
        unique case (tbl_reg)
            ppd_pkg::TBL_REQ:  tbl_hit = req_hit;
            ppd_pkg::TBL_SVC:  tbl_hit = svc_hit;
            ppd_pkg::TBL_ICMP: tbl_hit = icmp_hit;
            default:           tbl_hit = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        limit_next = limit_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        tbl_next   = tbl_reg;
        rd_req     = '0;
        wr_req     = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (act_reg)
                    ppd_pkg::ACT_CLASSIFY: begin
                        cnt_next  = '0;
                        pend_next = 1'b0;
                        if ((node_reg != ppd_pkg::UNASSIGNED_ADDR)
                            && (kind_reg == ppd_pkg::KIND_UDP)) begin
                            state_next = ST_SCAN;
                            if (port_reg >= ppd_pkg::DYN_PORT_BASE) begin
                                tbl_next   = ppd_pkg::TBL_REQ;
                                limit_next = RQ_CNT;
                            end else begin
                                tbl_next   = ppd_pkg::TBL_SVC;
                                limit_next = SV_CNT;
                            end
                        end else if (kind_reg == ppd_pkg::KIND_ICMP) begin
                            state_next = ST_SCAN;
                            tbl_next   = ppd_pkg::TBL_ICMP;
                            limit_next = IC_CNT;
                        end
                    end
                    ppd_pkg::ACT_ASSIGN: begin
                        if ({1'b0, ei_reg} < RQ_CNT) begin
                            rd_req.en  = 1'b1;
                            rd_req.tbl = ppd_pkg::TBL_REQ;
                            rd_req.idx = ei_reg;
                            state_next = ST_ASSIGN;
                        end
                    end
                    ppd_pkg::ACT_WR_REQ: begin
                        if ({1'b0, ei_reg} < RQ_CNT) begin
                            wr_req.en                  = 1'b1;
                            wr_req.tbl                 = ppd_pkg::TBL_REQ;
                            wr_req.idx                 = ei_reg;
                            wr_req.req.active          = eact_reg;
                            wr_req.req.next_port       = rb_reg;
                            wr_req.req.range_end       = re_reg;
                            wr_req.req.range_begin     = rb_reg;
                            wr_req.vld                 = evld_reg;
                            res_next.ok                = 1'b1;
                        end
                    end
                    ppd_pkg::ACT_WR_SVC: begin
                        if ({1'b0, ei_reg} < SV_CNT) begin
                            wr_req.en       = 1'b1;
                            wr_req.tbl      = ppd_pkg::TBL_SVC;
                            wr_req.idx      = ei_reg;
                            wr_req.svc_port = port_reg;
                            wr_req.vld      = evld_reg;
                            res_next.ok     = 1'b1;
                        end
                    end
                    ppd_pkg::ACT_WR_ICMP: begin
                        if ({1'b0, ei_reg} < IC_CNT) begin
                            wr_req.en       = 1'b1;
                            wr_req.tbl      = ppd_pkg::TBL_ICMP;
                            wr_req.idx      = ei_reg;
                            wr_req.msg_type = mtype_reg;
                            wr_req.vld      = evld_reg;
                            res_next.ok     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ASSIGN: begin
                state_next = ST_DONE;
                // read-modify-write of the next port, valid mark kept
                if (rd_rsp.req_vld) begin
                    res_next.ok          = 1'b1;
                    res_next.sport       = rd_rsp.req.next_port;
                    wr_req.en            = 1'b1;
                    wr_req.tbl           = ppd_pkg::TBL_REQ;
                    wr_req.idx           = ei_reg;
                    wr_req.req           = rd_rsp.req;
                    wr_req.req.next_port = (port_inc == rd_rsp.req.range_end)
                                           ? rd_rsp.req.range_begin : port_inc;
                    wr_req.vld           = 1'b1;
                end
            end
            ST_SCAN: begin
                if (pend_reg && tbl_hit) begin
                    state_next = ST_DONE;
                    unique case (tbl_reg)
                        ppd_pkg::TBL_REQ: begin
                            if (rd_rsp.req.active) begin
                                res_next.dst = ppd_pkg::DST_REQ;
                                res_next.idx = pidx_reg;
                            end
                        end
                        ppd_pkg::TBL_SVC: begin
                            res_next.dst = ppd_pkg::DST_SVC;
                            res_next.idx = pidx_reg;
                        end
                        ppd_pkg::TBL_ICMP: begin
                            res_next.dst = ppd_pkg::DST_ICMP;
                            res_next.idx = pidx_reg;
                        end
                        default: begin
                        end
                    endcase
                end else if (cnt_reg < limit_reg) begin
                    rd_req.en  = 1'b1;
                    rd_req.tbl = tbl_reg;
                    rd_req.idx = cnt_reg[ppd_pkg::IDX_W-1:0];
                    pend_next  = 1'b1;
                    pidx_next  = cnt_reg[ppd_pkg::IDX_W-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            node_reg     <= ppd_pkg::UNASSIGNED_ADDR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                node_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            act_reg   <= ppd_pkg::action_t'(s_tuser[2:0]);
            kind_reg  <= s_tuser[4:3];
            port_reg  <= s_tdata[15:0];
            mtype_reg <= s_tdata[23:16];
            ei_reg    <= s_tdata[27:24];
            rb_reg    <= s_tdata[43:28];
            re_reg    <= s_tdata[59:44];
            eact_reg  <= s_tdata[60];
            evld_reg  <= s_tdata[61];
        end
        res_reg   <= res_next;
        limit_reg <= limit_next;
        pidx_reg  <= pidx_next;
        tbl_reg   <= tbl_next;
        if (out_load) begin
            m_tdata_reg <= {1'b0, res_reg.ok, res_reg.sport, res_reg.idx, res_reg.dst};
        end
    end

    a_free_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ppd_pkg::DST_FREE) |-> (m_tdata[5:2] == 4'd0))
        else $error("free-list result with nonzero index");

    a_ok_not_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22] |-> (m_tdata[1:0] == ppd_pkg::DST_FREE))
        else $error("ok set on a delivery result");

    a_port_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[21:6] != 16'd0) |-> m_tdata[22])
        else $error("source port given without ok");

    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && pend_reg |-> ({1'b0, pidx_reg} < limit_reg))
        else $error("scan index beyond table");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire
